[sv/msdf_pkg.sv]
// Shared types, constants and saturation helpers for the MSD linear-fit block.
package msdf_pkg;

  // Field widths of the sample and the exact accumulators.
  localparam int unsigned XW     = 20;
  localparam int unsigned YW     = 24;
  localparam int unsigned CNT_W  = 17;
  localparam int unsigned SKIP_W = 16;
  localparam int unsigned STEP_W = 32;
  localparam int unsigned SX_W   = 36;
  localparam int unsigned SY_W   = 40;
  localparam int unsigned SXX_W  = 56;
  localparam int unsigned SXY_W  = 60;
  localparam int unsigned SYY_W  = 64;

  // Working width of the wide arithmetic unit and of the centered sums.
  localparam int unsigned BIG_W  = 256;
  localparam int unsigned HALF_W = 128;
  localparam int unsigned ROOT_W = 31;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_SKIP = 2'd0,
    REG_DIMS = 2'd1,
    REG_STEP = 2'd2
  } reg_idx_e;

  // Result status codes.
  typedef enum logic [2:0] {
    STAT_OK     = 3'd0,
    STAT_FEW    = 3'd1,
    STAT_XCONST = 3'd2,
    STAT_YCONST = 3'd3,
    STAT_OVER   = 3'd4
  } status_e;

  // Operations of the wide arithmetic unit.
  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } arith_op_e;

  typedef struct packed {
    logic [XW-1:0] time_step;
    logic [YW-1:0] msd_value;
    logic          last;
  } in_t;

  typedef struct packed {
    logic [2:0]          status;
    logic signed [47:0]  slope;
    logic signed [31:0]  intercept;
    logic signed [31:0]  corr;
    logic signed [47:0]  diffusion;
  } out_t;

  // Sums of one finished data set, handed from the front to the back.
  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [SX_W-1:0]  sx;
    logic [SY_W-1:0]  sy;
    logic [SXX_W-1:0] sxx;
    logic [SXY_W-1:0] sxy;
    logic [SYY_W-1:0] syy;
    logic             ovf;
  } set_t;

  typedef struct packed {
    logic [SKIP_W-1:0] skip;
    logic              dims;
    logic [STEP_W-1:0] step;
  } cfg_t;

  typedef struct packed {
    logic             start;
    arith_op_e        op;
    logic [BIG_W-1:0] a;
    logic [BIG_W-1:0] b;
  } arith_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [BIG_W-1:0] res;
  } arith_rsp_t;

  // Clamp a sign-magnitude value into a signed 48-bit field.
  function automatic logic [47:0] sat48(logic [BIG_W-1:0] mag, logic neg);
    logic [47:0] r;
    if (neg) begin
      if ((|mag[BIG_W-1:48]) || (mag[47] && (|mag[46:0]))) r = {1'b1, 47'd0};
      else r = 48'd0 - mag[47:0];
    end else begin
      if (|mag[BIG_W-1:47]) r = {1'b0, {47{1'b1}}};
      else r = mag[47:0];
    end
    return r;
  endfunction

  // Clamp a sign-magnitude value into a signed 32-bit field.
  function automatic logic [31:0] sat32(logic [BIG_W-1:0] mag, logic neg);
    logic [31:0] r;
    if (neg) begin
      if ((|mag[BIG_W-1:32]) || (mag[31] && (|mag[30:0]))) r = {1'b1, 31'd0};
      else r = 32'd0 - mag[31:0];
    end else begin
      if (|mag[BIG_W-1:31]) r = {1'b0, {31{1'b1}}};
      else r = mag[31:0];
    end
    return r;
  endfunction

endpackage

[sv/msdf_queue.sv]
// Small first-in first-out queue of registers for any payload type.
module msdf_queue #(
  parameter type T = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);
  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  T                entries_q [DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = entries_q[rd_q];

  // Pointer and fill-count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Payload storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_q] <= data_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("queue written while full");
`endif

endmodule

[sv/msdf_front.sv]
// Sample front end: skip filter, exact running sums, and data-set hand-off.
module msdf_front #(
  parameter int unsigned MAX_SAMPLES = 65536,
  parameter int unsigned X_BITS = 20,
  parameter int unsigned Y_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  msdf_pkg::in_t         sample_i,
  input  logic [15:0]           skip_i,
  output logic                  set_push_o,
  output msdf_pkg::set_t        set_o
);
  import msdf_pkg::*;

  logic [SKIP_W-1:0] skipped_q, skipped_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SX_W-1:0]   sx_q, sx_d;
  logic [SY_W-1:0]   sy_q, sy_d;
  logic [SXX_W-1:0]  sxx_q, sxx_d;
  logic [SXY_W-1:0]  sxy_q, sxy_d;
  logic [SYY_W-1:0]  syy_q, syy_d;
  logic              ovf_q, ovf_d;

  logic [XW-1:0]     xv;
  logic [YW-1:0]     yv;
  logic [2*XW-1:0]   xx;
  logic [XW+YW-1:0]  xy;
  logic [2*YW-1:0]   yy;

  // Only the low sample bits take part in the fit.
  assign xv = XW'(sample_i.time_step[X_BITS-1:0]);
  assign yv = YW'(sample_i.msd_value[Y_BITS-1:0]);
  assign xx = xv * xv;
  assign xy = xv * yv;
  assign yy = yv * yv;

  // Fold one transfer into the sums; a last sample hands the set over.
  always_comb begin
    skipped_d  = skipped_q;
    cnt_d      = cnt_q;
    sx_d       = sx_q;
    sy_d       = sy_q;
    sxx_d      = sxx_q;
    sxy_d      = sxy_q;
    syy_d      = syy_q;
    ovf_d      = ovf_q;
    set_push_o = 1'b0;
    if (accept_i) begin
      if (skipped_q < skip_i) begin
        skipped_d = skipped_q + SKIP_W'(1);
      end else if (cnt_q < CNT_W'(MAX_SAMPLES)) begin
        cnt_d = cnt_q + CNT_W'(1);
        sx_d  = sx_q + SX_W'(xv);
        sy_d  = sy_q + SY_W'(yv);
        sxx_d = sxx_q + SXX_W'(xx);
        sxy_d = sxy_q + SXY_W'(xy);
        syy_d = syy_q + SYY_W'(yy);
      end else begin
        ovf_d = 1'b1;
      end
    end
    set_o.n   = cnt_d;
    set_o.sx  = sx_d;
    set_o.sy  = sy_d;
    set_o.sxx = sxx_d;
    set_o.sxy = sxy_d;
    set_o.syy = syy_d;
    set_o.ovf = ovf_d;
    if (accept_i && sample_i.last) begin
      set_push_o = 1'b1;
      skipped_d  = '0;
      cnt_d      = '0;
      sx_d       = '0;
      sy_d       = '0;
      sxx_d      = '0;
      sxy_d      = '0;
      syy_d      = '0;
      ovf_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skipped_q <= '0;
      cnt_q     <= '0;
      sx_q      <= '0;
      sy_q      <= '0;
      sxx_q     <= '0;
      sxy_q     <= '0;
      syy_q     <= '0;
      ovf_q     <= 1'b0;
    end else begin
      skipped_q <= skipped_d;
      cnt_q     <= cnt_d;
      sx_q      <= sx_d;
      sy_q      <= sy_d;
      sxx_q     <= sxx_d;
      sxy_q     <= sxy_d;
      syy_q     <= syy_d;
      ovf_q     <= ovf_d;
    end
  end

endmodule

[sv/msdf_arith.sv]
// Shared wide arithmetic unit: shift-add multiply, restoring divide, bit-wise root.
module msdf_arith (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  msdf_pkg::arith_req_t req_i,
  output msdf_pkg::arith_rsp_t rsp_o
);
  import msdf_pkg::*;

  localparam int unsigned CNT_BITS = $clog2(BIG_W + 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  arith_op_e           op_q, op_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic [BIG_W-1:0]    acc_q, acc_d;
  logic [BIG_W-1:0]    x_q, x_d;
  logic [BIG_W-1:0]    y_q, y_d;
  logic [BIG_W-1:0]    res_q, res_d;

  logic [BIG_W:0]      trem;
  logic [BIG_W:0]      tsub;
  logic                ge;
  logic [4:0]          bit_idx;
  logic [ROOT_W-1:0]   trial;
  logic [2*ROOT_W-1:0] sq;

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

  // Divider step: shift one numerator bit into the remainder and try the divisor.
  assign trem = {acc_q, x_q[BIG_W-1]};
  assign tsub = trem - {1'b0, y_q};
  assign ge   = (trem >= {1'b0, y_q});

  // Root step: try the next result bit and compare its square to the radicand.
  assign bit_idx = 5'(cnt_q - CNT_BITS'(1));
  assign trial   = x_q[ROOT_W-1:0] | (ROOT_W'(1) << bit_idx);
  assign sq      = trial * trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    x_d    = x_q;
    y_d    = y_q;
    res_d  = res_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      acc_d  = '0;
      case (req_i.op)
        OP_MUL: begin
          x_d = req_i.a;
          y_d = req_i.b;
        end
        OP_DIV: begin
          x_d   = req_i.a;
          y_d   = req_i.b;
          cnt_d = CNT_BITS'(BIG_W);
        end
        OP_SQRT: begin
          x_d   = '0;
          y_d   = req_i.a;
          cnt_d = CNT_BITS'(ROOT_W);
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end else if (busy_q) begin
      case (op_q)
        OP_MUL: begin
          if (y_q == '0) begin
            res_d  = acc_q;
            done_d = 1'b1;
            busy_d = 1'b0;
          end else begin
            acc_d = y_q[0] ? acc_q + x_q : acc_q;
            x_d   = x_q << 1;
            y_d   = y_q >> 1;
          end
        end
        OP_DIV: begin
          acc_d = ge ? tsub[BIG_W-1:0] : trem[BIG_W-1:0];
          x_d   = {x_q[BIG_W-2:0], ge};
          cnt_d = cnt_q - CNT_BITS'(1);
          if (cnt_q == CNT_BITS'(1)) begin
            res_d  = x_d;
            done_d = 1'b1;
            busy_d = 1'b0;
          end
        end
        OP_SQRT: begin
          if (BIG_W'(sq) <= y_q) begin
            x_d = BIG_W'(trial);
          end
          cnt_d = cnt_q - CNT_BITS'(1);
          if (cnt_q == CNT_BITS'(1)) begin
            res_d  = BIG_W'(x_d[ROOT_W-1:0]);
            done_d = 1'b1;
            busy_d = 1'b0;
          end
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
    res_q <= res_d;
  end

`ifndef ASSERT_OFF
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("arithmetic unit started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(busy_q) && !busy_q))
    else $error("arithmetic result without a running operation");
`endif

endmodule

[sv/msdf_back.sv]
// Fit sequencer: turns the sums of a data set into slope, intercept, r and diffusion.
module msdf_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  msdf_pkg::cfg_t       cfg_i,
  input  logic                 set_valid_i,
  input  msdf_pkg::set_t       set_i,
  output logic                 set_pop_o,
  output msdf_pkg::arith_req_t req_o,
  input  msdf_pkg::arith_rsp_t rsp_i,
  input  logic                 res_full_i,
  output logic                 res_push_o,
  output msdf_pkg::out_t       res_o
);
  import msdf_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_SXX_A = 18'h00002,
    S_SXX_B = 18'h00004,
    S_SYY_A = 18'h00008,
    S_SYY_B = 18'h00010,
    S_SXY_A = 18'h00020,
    S_SXY_B = 18'h00040,
    S_SLOPE = 18'h00080,
    S_ICP_A = 18'h00100,
    S_ICP_B = 18'h00200,
    S_ICP_D = 18'h00400,
    S_PROD  = 18'h00800,
    S_SQR   = 18'h01000,
    S_CDIV  = 18'h02000,
    S_ROOT  = 18'h04000,
    S_DEN   = 18'h08000,
    S_DDIV  = 18'h10000,
    S_PUSH  = 18'h20000
  } state_e;

  state_e            state_q, state_d;
  logic              issued_q, issued_d;
  set_t              set_q, set_d;
  logic [HALF_W-1:0] sxx_q, sxx_d, syy_q, syy_d, sxy_q, sxy_d;
  logic              sneg_q, sneg_d, ineg_q, ineg_d;
  logic [BIG_W-1:0]  tmp_a_q, tmp_a_d, tmp_b_q, tmp_b_d;
  out_t              res_q, res_d;

  logic [STEP_W-1:0] step_eff;
  logic [STEP_W+2:0] kfac;
  logic              a_ge;
  logic [BIG_W-1:0]  a_mag;

  assign res_o = res_q;

  // Time scale factor: step times four in 2D, times six in 3D.
  assign step_eff = (cfg_i.step == '0) ? STEP_W'(1) : cfg_i.step;
  assign kfac = cfg_i.dims ? ((STEP_W+3)'(step_eff) << 2) + ((STEP_W+3)'(step_eff) << 1)
                           : ((STEP_W+3)'(step_eff) << 2);

  // Magnitude and sign of the held product minus the fresh one.
  assign a_ge  = (tmp_a_q >= rsp_i.res);
  assign a_mag = a_ge ? tmp_a_q - rsp_i.res : rsp_i.res - tmp_a_q;

  // Operand selection for each step of the fit.
  always_comb begin
    req_o.start = 1'b0;
    req_o.op    = OP_MUL;
    req_o.a     = '0;
    req_o.b     = '0;
    case (state_q)
      S_SXX_A: begin
        req_o.a = BIG_W'(set_q.sxx);
        req_o.b = BIG_W'(set_q.n);
      end
      S_SXX_B: begin
        req_o.a = BIG_W'(set_q.sx);
        req_o.b = BIG_W'(set_q.sx);
      end
      S_SYY_A: begin
        req_o.a = BIG_W'(set_q.syy);
        req_o.b = BIG_W'(set_q.n);
      end
      S_SYY_B: begin
        req_o.a = BIG_W'(set_q.sy);
        req_o.b = BIG_W'(set_q.sy);
      end
      S_SXY_A: begin
        req_o.a = BIG_W'(set_q.sxy);
        req_o.b = BIG_W'(set_q.n);
      end
      S_SXY_B: begin
        req_o.a = BIG_W'(set_q.sy);
        req_o.b = BIG_W'(set_q.sx);
      end
      S_SLOPE: begin
        req_o.op = OP_DIV;
        req_o.a  = BIG_W'(sxy_q) << 8;
        req_o.b  = BIG_W'(sxx_q);
      end
      S_ICP_A: begin
        req_o.a = BIG_W'(set_q.sxx);
        req_o.b = BIG_W'(set_q.sy);
      end
      S_ICP_B: begin
        req_o.a = BIG_W'(set_q.sxy);
        req_o.b = BIG_W'(set_q.sx);
      end
      S_ICP_D: begin
        req_o.op = OP_DIV;
        req_o.a  = tmp_a_q;
        req_o.b  = BIG_W'(sxx_q);
      end
      S_PROD: begin
        req_o.a = BIG_W'(syy_q);
        req_o.b = BIG_W'(sxx_q);
      end
      S_SQR: begin
        req_o.a = BIG_W'(sxy_q);
        req_o.b = BIG_W'(sxy_q);
      end
      S_CDIV: begin
        req_o.op = OP_DIV;
        req_o.a  = tmp_b_q;
        req_o.b  = tmp_a_q;
      end
      S_ROOT: begin
        req_o.op = OP_SQRT;
        req_o.a  = tmp_a_q;
      end
      S_DEN: begin
        req_o.a = BIG_W'(sxx_q);
        req_o.b = BIG_W'(kfac);
      end
      S_DDIV: begin
        req_o.op = OP_DIV;
        req_o.a  = BIG_W'(sxy_q) << 32;
        req_o.b  = tmp_a_q;
      end
      default: begin
        req_o.op = OP_MUL;
      end
    endcase
    if (state_q != S_IDLE && state_q != S_PUSH && !issued_q) begin
      req_o.start = 1'b1;
    end
  end

  // Sequencer: each step issues one operation and stores what comes back.
  always_comb begin
    state_d    = state_q;
    issued_d   = issued_q;
    set_d      = set_q;
    sxx_d      = sxx_q;
    syy_d      = syy_q;
    sxy_d      = sxy_q;
    sneg_d     = sneg_q;
    ineg_d     = ineg_q;
    tmp_a_d    = tmp_a_q;
    tmp_b_d    = tmp_b_q;
    res_d      = res_q;
    set_pop_o  = 1'b0;
    res_push_o = 1'b0;
    if (req_o.start) begin
      issued_d = 1'b1;
    end
    if (rsp_i.done) begin
      issued_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (set_valid_i) begin
          set_d     = set_i;
          set_pop_o = 1'b1;
          res_d     = '0;
          state_d   = S_SXX_A;
        end
      end
      S_SXX_A, S_SYY_A, S_SXY_A, S_ICP_A, S_PROD, S_DEN: begin
        if (rsp_i.done) begin
          tmp_a_d = rsp_i.res;
          case (state_q)
            S_SXX_A: state_d = S_SXX_B;
            S_SYY_A: state_d = S_SYY_B;
            S_SXY_A: state_d = S_SXY_B;
            S_ICP_A: state_d = S_ICP_B;
            S_PROD:  state_d = S_SQR;
            S_DEN:   state_d = S_DDIV;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SXX_B: begin
        if (rsp_i.done) begin
          sxx_d   = a_mag[HALF_W-1:0];
          state_d = S_SYY_A;
        end
      end
      S_SYY_B: begin
        if (rsp_i.done) begin
          syy_d   = a_mag[HALF_W-1:0];
          state_d = S_SXY_A;
        end
      end
      S_SXY_B: begin
        if (rsp_i.done) begin
          sxy_d  = a_mag[HALF_W-1:0];
          sneg_d = !a_ge;
          if (set_q.n < CNT_W'(2)) begin
            res_d.status = STAT_FEW;
            state_d      = S_PUSH;
          end else if (sxx_q == '0) begin
            res_d.status = STAT_XCONST;
            state_d      = S_PUSH;
          end else begin
            state_d = S_SLOPE;
          end
        end
      end
      S_SLOPE: begin
        if (rsp_i.done) begin
          res_d.slope = sat48(rsp_i.res, sneg_q);
          state_d     = S_ICP_A;
        end
      end
      S_ICP_B: begin
        if (rsp_i.done) begin
          tmp_a_d = a_mag;
          ineg_d  = !a_ge;
          state_d = S_ICP_D;
        end
      end
      S_ICP_D: begin
        if (rsp_i.done) begin
          res_d.intercept = sat32(rsp_i.res, ineg_q);
          if (syy_q == '0) begin
            res_d.status = STAT_YCONST;
            state_d      = S_PUSH;
          end else begin
            state_d = S_PROD;
          end
        end
      end
      S_SQR: begin
        if (rsp_i.done) begin
          tmp_b_d = rsp_i.res << 60;
          state_d = S_CDIV;
        end
      end
      S_CDIV: begin
        if (rsp_i.done) begin
          tmp_a_d = rsp_i.res;
          state_d = S_ROOT;
        end
      end
      S_ROOT: begin
        if (rsp_i.done) begin
          res_d.corr = sat32(rsp_i.res, sneg_q);
          state_d    = S_DEN;
        end
      end
      S_DDIV: begin
        if (rsp_i.done) begin
          res_d.diffusion = sat48(rsp_i.res, sneg_q);
          res_d.status    = set_q.ovf ? STAT_OVER : STAT_OK;
          state_d         = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
    end
  end

  // Working values of the fit.
  always_ff @(posedge clk_i) begin
    set_q   <= set_d;
    sxx_q   <= sxx_d;
    syy_q   <= syy_d;
    sxy_q   <= sxy_d;
    sneg_q  <= sneg_d;
    ineg_q  <= ineg_d;
    tmp_a_q <= tmp_a_d;
    tmp_b_q <= tmp_b_d;
    res_q   <= res_d;
  end

`ifndef ASSERT_OFF
  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_o.start |-> !rsp_i.busy)
    else $error("operation issued while the arithmetic unit is busy");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result written while the result queue is full");
`endif

endmodule

[sv/msd_linear_fit_diffusion.sv]
// Top level of the MSD least-squares fit and diffusion coefficient block.
//
//   channel   direction  handshake           payload
//   samples   in         push / full         in_data_i (time_step, msd_value, last)
//   results   out        empty / pop         out_data_o (status .. diffusion)
//   config    in         cfg_we_i            cfg_idx_i, cfg_data_i
//
// A sample is folded into the sums in the cycle of its transfer; samples stream
// at one per cycle while full is low. A last sample hands its sums to a
// two-entry set queue, and full stays high while that queue is full. The fit
// sequencer then works through a data set on the shared bit-serial multiplier
// (one operand bit per cycle) and four restoring divides; a set that stops
// at too few samples or constant x skips the divides.
// Reset clears the control state and the running sums at once; no clearing pass is needed.
// A waiting result holds the sequencer once the two-entry result queue is full;
// sampling then stalls only when the set queue fills as well.
module msd_linear_fit_diffusion #(
  parameter int unsigned MAX_SAMPLES = 65536,
  parameter int unsigned X_BITS = 20,
  parameter int unsigned Y_BITS = 24
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  msdf_pkg::in_t  in_data_i,
  output logic           empty,
  input  logic           pop,
  output msdf_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [31:0]    cfg_data_i
);
  import msdf_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       accept;
  logic       set_push, set_pop, set_full, set_empty;
  set_t       set_in, set_out;
  logic       res_push, res_full;
  out_t       res_in;
  arith_req_t req;
  arith_rsp_t rsp;

  // Configuration register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SKIP: cfg_d.skip = cfg_data_i[SKIP_W-1:0];
        REG_DIMS: cfg_d.dims = cfg_data_i[0];
        REG_STEP: cfg_d.step = cfg_data_i[STEP_W-1:0];
        default:  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.skip <= '0;
      cfg_q.dims <= 1'b1;
      cfg_q.step <= STEP_W'(33554);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Sample transfer.
  assign full   = set_full;
  assign accept = push && !set_full;

  msdf_front #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .X_BITS(X_BITS),
    .Y_BITS(Y_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .sample_i  (in_data_i),
    .skip_i    (cfg_q.skip),
    .set_push_o(set_push),
    .set_o     (set_in)
  );

  msdf_queue #(.T(set_t), .DEPTH(2)) u_set_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (set_push),
    .data_i (set_in),
    .full_o (set_full),
    .pop_i  (set_pop),
    .data_o (set_out),
    .empty_o(set_empty)
  );

  msdf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .set_valid_i(!set_empty),
    .set_i      (set_out),
    .set_pop_o  (set_pop),
    .req_o      (req),
    .rsp_i      (rsp),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  msdf_arith u_arith (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  msdf_queue #(.T(out_t), .DEPTH(2)) u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop && !empty),
    .data_o (out_data_o),
    .empty_o(empty)
  );

endmodule
